FILE: src/jsu_pkg.sv
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_NOQUOTE = 3'd2,
        ST_CTRL    = 3'd3,
        ST_BADESC  = 3'd4,
        ST_BADHEX  = 3'd5,
        ST_UNTERM  = 3'd6
    } t_status;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    localparam logic [15:0] CP_MAX1 = 16'h007f;
    localparam logic [15:0] CP_MAX2 = 16'h07ff;
    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] CONT = 8'h80;

    // One decoded input byte: up to three result bytes, cnt is the count minus one.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] cnt;
        logic       valid;
        t_status    status;
    } t_task;

    // Returns {ok, digit value}.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: src/json_string_unescape.sv
// JSON string unescaper. Each input request carries one text byte of a JSON
// string literal, starting at the opening quote, with i_first set on that
// quote to restart parsing. Ordinary bytes pass through, simple escapes
// become their bytes, and a backslash-u escape becomes one to three UTF-8
// bytes once its fourth hex digit arrives. Every input byte yields at least
// one result; a byte that decodes to nothing yields one result with
// o_out_valid low and the current status. o_last marks the final result of
// each input byte.
// Input side: a request is taken when push is high and full is low. The
// parser decodes it in the same cycle and writes the decoded work into a
// QUEUE_DEPTH entry queue. Result side: the oldest result is shown while
// empty is low and is taken when pop is high.
// A request passes through the queue and the result register before its
// first result is shown. The result register emits one result per cycle
// while pop stays high, and a byte makes one to three results. When pop
// stays low the queue fills and full rises; no request is lost. Reset
// empties the queue and returns the parser to waiting for an opening quote.
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_first,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output logic       o_last
);

    t_task front_task, head_task;
    logic  q_empty, take, accept;

    assign accept = push && !full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .o_task      (front_task)
    );

    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_task (front_task),
        .o_full    (full),
        .i_rd      (take),
        .o_rd_task (head_task),
        .o_empty   (q_empty)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_has_task  (!q_empty),
        .i_task      (head_task),
        .o_take      (take),
        .pop         (pop),
        .empty       (empty),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

FILE: src/jsu_front.sv
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_first,
    output t_task      o_task
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_hex_count, n_hex_count;
    logic [15:0] r_code_point, n_code_point;
    t_status    r_final, n_final;

    t_phase     cur_phase;
    logic [1:0] cur_hex_count;
    logic [15:0] cur_code_point;
    t_status    cur_final;
    logic [4:0] hex;
    logic [15:0] cp_new;
    t_task      tsk;

    always_comb begin
        cur_phase      = i_first ? PH_OPEN : r_phase;
        cur_hex_count  = i_first ? 2'd0 : r_hex_count;
        cur_code_point = i_first ? 16'd0 : r_code_point;
        cur_final      = i_first ? ST_RUN : r_final;
        hex            = hex_value(i_data_byte);
        cp_new         = {cur_code_point[11:0], hex[3:0]};
    end

    always_comb begin
        n_phase = cur_phase;
        unique case (cur_phase)
            PH_OPEN: begin
                n_phase = (i_data_byte == CH_QUOTE) ? PH_BODY : PH_DONE;
            end
            PH_BODY: begin
                if (i_data_byte == CH_NUL || i_data_byte == CH_QUOTE ||
                    i_data_byte < CH_SPACE) begin
                    n_phase = PH_DONE;
                end else if (i_data_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end
            end
            PH_ESC: begin
                case (i_data_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
                        n_phase = PH_BODY;
                    CH_U:    n_phase = PH_HEX;
                    default: n_phase = PH_DONE;
                endcase
            end
            PH_HEX: begin
                if (!hex[4]) begin
                    n_phase = PH_DONE;
                end else if (cur_hex_count == 2'd3) begin
                    n_phase = PH_BODY;
                end
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    always_comb begin
        n_hex_count  = cur_hex_count;
        n_code_point = cur_code_point;
        n_final      = cur_final;
        tsk          = '0;
        tsk.status   = ST_RUN;
        unique case (cur_phase)
            PH_OPEN: begin
                if (i_data_byte != CH_QUOTE) begin
                    n_final = ST_NOQUOTE;
                end
            end
            PH_BODY: begin
                if (i_data_byte == CH_NUL) begin
                    n_final = ST_UNTERM;
                end else if (i_data_byte == CH_QUOTE) begin
                    n_final = ST_CLOSED;
                end else if (i_data_byte < CH_SPACE) begin
                    n_final = ST_CTRL;
                end else if (i_data_byte != CH_BSLASH) begin
                    tsk.valid = 1'b1;
                    tsk.byte0 = i_data_byte;
                end
            end
            PH_ESC: begin
                tsk.valid = 1'b1;
                case (i_data_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: tsk.byte0 = i_data_byte;
                    CH_B: tsk.byte0 = 8'h08;
                    CH_F: tsk.byte0 = 8'h0c;
                    CH_N: tsk.byte0 = 8'h0a;
                    CH_R: tsk.byte0 = 8'h0d;
                    CH_T: tsk.byte0 = 8'h09;
                    CH_U: begin
                        tsk.valid    = 1'b0;
                        n_hex_count  = 2'd0;
                        n_code_point = 16'd0;
                    end
                    default: begin
                        tsk.valid = 1'b0;
                        n_final   = ST_BADESC;
                    end
                endcase
            end
            PH_HEX: begin
                if (!hex[4]) begin
                    n_final = ST_BADHEX;
                end else begin
                    n_code_point = cp_new;
                    n_hex_count  = cur_hex_count + 2'd1;
                    if (cur_hex_count == 2'd3) begin
                        tsk.valid = 1'b1;
                        if (cp_new <= CP_MAX1) begin
                            tsk.byte0 = cp_new[7:0];
                        end else if (cp_new <= CP_MAX2) begin
                            tsk.cnt   = 2'd1;
                            tsk.byte0 = LEAD2 | {3'd0, cp_new[10:6]};
                            tsk.byte1 = CONT | {2'd0, cp_new[5:0]};
                        end else begin
                            tsk.cnt   = 2'd2;
                            tsk.byte0 = LEAD3 | {4'd0, cp_new[15:12]};
                            tsk.byte1 = CONT | {2'd0, cp_new[11:6]};
                            tsk.byte2 = CONT | {2'd0, cp_new[5:0]};
                        end
                    end
                end
            end
            PH_DONE: ;
            default: ;
        endcase
        tsk.status = (n_phase == PH_DONE) ? n_final : ST_RUN;
    end

    assign o_task = tsk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPEN;
            r_hex_count  <= 2'd0;
            r_code_point <= 16'd0;
            r_final      <= ST_RUN;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_hex_count  <= n_hex_count;
            r_code_point <= n_code_point;
            r_final      <= n_final;
        end
    end

endmodule

FILE: src/jsu_fifo.sv
module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_task i_wr_task,
    output logic  o_full,
    input  logic  i_rd,
    output t_task o_rd_task,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_task r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic wr_en, rd_en;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_task = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: src/jsu_back.sv
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_has_task,
    input  t_task      i_task,
    output logic       o_take,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic       r_full;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_valid;
    logic [2:0] r_status;
    logic       r_last;
    logic       load, is_last;
    logic [7:0] sel_byte;

    assign load    = i_has_task && (!r_full || pop);
    assign is_last = (r_idx == i_task.cnt);
    assign o_take  = load && is_last;

    always_comb begin
        case (r_idx)
            2'd1:    sel_byte = i_task.byte1;
            2'd2:    sel_byte = i_task.byte2;
            default: sel_byte = i_task.byte0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_full <= 1'b1;
            r_idx  <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= sel_byte;
            r_valid  <= i_task.valid;
            r_status <= i_task.status;
            r_last   <= is_last;
        end
    end

    assign empty       = !r_full;
    assign o_out_byte  = r_byte;
    assign o_out_valid = r_valid;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

FILE: src/jsu_checker.sv
module jsu_checker
    import jsu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic [2:0] o_status,
    input logic       o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("Result present right after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_last))
        else $error("Stalled result changed.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out_valid |-> o_out_byte == 8'd0 && o_last)
        else $error("Result without a byte is not a lone zero result.");

    a_stop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_RUN |-> !o_out_valid && o_last)
        else $error("Stopped status carries a byte.");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_out_byte  (o_out_byte),
    .o_out_valid (o_out_valid),
    .o_status    (o_status),
    .o_last      (o_last)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

import jsu_pkg::*;

typedef struct packed {
    logic [7:0] data;
    logic       valid;
    t_status    status;
    logic       last;
} t_decoded;

function automatic int nibble_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
endfunction

class unescape_scoreboard;
    t_phase      phase;
    logic [1:0]  hex_cnt;
    logic [15:0] code_point;
    t_status     stop_status;
    t_decoded    decoded_q[$];
    int          n_requests;
    int          n_strings;
    int          n_results;
    int          n_mismatch;
    int          status_hits[8];

    function new();
        restart();
        n_requests = 0;
        n_strings = 0;
        n_results = 0;
        n_mismatch = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void restart();
        phase = PH_OPEN;
        hex_cnt = 2'd0;
        code_point = 16'd0;
        stop_status = ST_RUN;
    endfunction

    function void halt(t_status s);
        phase = PH_DONE;
        stop_status = s;
    endfunction

    function void emit(logic [7:0] d);
        t_decoded r;
        r.data = d;
        r.valid = 1'b1;
        r.status = ST_RUN;
        r.last = 1'b0;
        decoded_q.push_back(r);
    endfunction

    function void encode_utf8();
        if (code_point <= CP_MAX1) begin
            emit(code_point[7:0]);
        end else if (code_point <= CP_MAX2) begin
            emit(LEAD2 | {3'b000, code_point[10:6]});
            emit(CONT | {2'b00, code_point[5:0]});
        end else begin
            emit(LEAD3 | {4'b0000, code_point[15:12]});
            emit(CONT | {2'b00, code_point[11:6]});
            emit(CONT | {2'b00, code_point[5:0]});
        end
    endfunction

    function void note_request(logic [7:0] b, logic first);
        int       base;
        int       d;
        t_decoded r;
        base = decoded_q.size();
        n_requests++;
        if (first) begin
            restart();
            n_strings++;
        end
        case (phase)
            PH_OPEN: begin
                if (b == CH_QUOTE) phase = PH_BODY;
                else halt(ST_NOQUOTE);
            end
            PH_BODY: begin
                if (b == CH_NUL) halt(ST_UNTERM);
                else if (b == CH_QUOTE) halt(ST_CLOSED);
                else if (b < CH_SPACE) halt(ST_CTRL);
                else if (b == CH_BSLASH) phase = PH_ESC;
                else emit(b);
            end
            PH_ESC: begin
                phase = PH_BODY;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b);
                    CH_B: emit(8'h08);
                    CH_F: emit(8'h0c);
                    CH_N: emit(8'h0a);
                    CH_R: emit(8'h0d);
                    CH_T: emit(8'h09);
                    CH_U: begin
                        phase = PH_HEX;
                        hex_cnt = 2'd0;
                        code_point = 16'd0;
                    end
                    default: halt(ST_BADESC);
                endcase
            end
            PH_HEX: begin
                d = nibble_of(b);
                if (d < 0) begin
                    halt(ST_BADHEX);
                end else begin
                    code_point = {code_point[11:0], 4'(d)};
                    if (hex_cnt < 2'd3) begin
                        hex_cnt++;
                    end else begin
                        hex_cnt = 2'd0;
                        phase = PH_BODY;
                        encode_utf8();
                    end
                end
            end
            default: phase = PH_DONE;
        endcase
        if (decoded_q.size() == base) begin
            r.data = 8'h00;
            r.valid = 1'b0;
            r.status = (phase == PH_DONE) ? stop_status : ST_RUN;
            r.last = 1'b0;
            decoded_q.push_back(r);
        end
        decoded_q[decoded_q.size() - 1].last = 1'b1;
        status_hits[decoded_q[decoded_q.size() - 1].status]++;
    endfunction

    function void check_result(logic [7:0] d, logic v, logic [2:0] s, logic l);
        t_decoded e;
        n_results++;
        if (decoded_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("Result with nothing expected: byte %02h valid %0d status %0d last %0d",
                         d, v, s, l);
            return;
        end
        e = decoded_q.pop_front();
        if (d !== e.data || v !== e.valid || s !== e.status || l !== e.last) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display({"Mismatch: expected byte %02h valid %0d status %0d last %0d, ",
                          "got byte %02h valid %0d status %0d last %0d"},
                         e.data, e.valid, e.status, e.last, d, v, s, l);
        end
    endfunction

    function int pending();
        return decoded_q.size();
    endfunction
endclass

module tb_top;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
    } t_text;

    typedef enum {RX_STEADY, RX_COIN, RX_MASK, RX_SPARSE} t_rx_pattern;
    typedef enum {END_CLOSE, END_CTRL, END_NUL, END_BADESC, END_BADHEX, END_OPEN} t_ending;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 250;
    localparam logic [7:0] ESC_CHARS [8] =
        '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_first = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic [2:0] o_status;
    logic       o_last;

    unescape_scoreboard sb = new();
    t_text text_q[$];
    int    n_counted = 0;
    int    burst_left = 0;
    bit    tx_calm = 1'b0;
    bit    rx_hold_req = 1'b0;
    int    cycles = 0;

    json_string_unescape dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_data_byte(i_data_byte),
        .i_first(i_first),
        .empty(empty),
        .pop(pop),
        .o_out_byte(o_out_byte),
        .o_out_valid(o_out_valid),
        .o_status(o_status),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, sb.pending());
            $display("[json_string_unescape] ERROR");
            $finish;
        end
    end

    function automatic void add_text(logic [7:0] b, logic first, bit counted);
        t_text t;
        t.b = b;
        t.first = first;
        text_q.push_back(t);
        if (counted) n_counted++;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
        if (nib < 4'd10) return 8'("0") + 8'(nib);
        return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
    endfunction

    function automatic void add_unicode(logic [15:0] cp, int n_digits);
        add_text(CH_BSLASH, 1'b0, 1'b1);
        add_text(CH_U, 1'b0, 1'b1);
        for (int i = 3; i > 3 - n_digits; i--)
            add_text(hex_char(cp[4 * i +: 4], bit'($urandom_range(0, 1))), 1'b0, 1'b1);
    endfunction

    function automatic void add_token();
        int          kind;
        logic [7:0]  c;
        logic [15:0] cp;
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff};
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            add_text(c, 1'b0, 1'b1);
        end else if (kind < 7) begin
            add_text(CH_BSLASH, 1'b0, 1'b1);
            add_text(ESC_CHARS[$urandom_range(0, 7)], 1'b0, 1'b1);
        end else begin
            case ($urandom_range(0, 3))
                0: cp = 16'($urandom_range(0, 16'h7f));
                1: cp = 16'($urandom_range(16'h80, 16'h7ff));
                2: cp = 16'($urandom_range(16'h800, 16'hffff));
                default: cp = edges[$urandom_range(0, 5)];
            endcase
            add_unicode(cp, 4);
        end
    endfunction

    function automatic void add_string();
        int         r;
        t_ending    ending;
        logic [7:0] c;
        if ($urandom_range(0, 11) == 0) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
            add_text(c, 1'b1, 1'b1);
        end else begin
            add_text(CH_QUOTE, 1'b1, 1'b1);
            repeat ($urandom_range(0, 8)) add_token();
            r = $urandom_range(0, 11);
            ending = (r < 7) ? END_CLOSE : t_ending'(r - 6);
            case (ending)
                END_CLOSE: add_text(CH_QUOTE, 1'b0, 1'b1);
                END_CTRL: add_text(8'($urandom_range(1, 31)), 1'b0, 1'b1);
                END_NUL: add_text(CH_NUL, 1'b0, 1'b1);
                END_BADESC: begin
                    add_text(CH_BSLASH, 1'b0, 1'b1);
                    do c = 8'($urandom_range(0, 255));
                    while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                                     CH_R, CH_T, CH_U});
                    add_text(c, 1'b0, 1'b1);
                end
                END_BADHEX: begin
                    add_unicode(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 3));
                    do c = 8'($urandom_range(0, 255));
                    while (nibble_of(c) >= 0);
                    add_text(c, 1'b0, 1'b1);
                end
                default: ;
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add_text(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endfunction

    task automatic send_req(logic [7:0] b, logic first);
        i_data_byte <= b;
        i_first <= first;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(b, first);
    endtask

    task automatic send_all();
        t_text t;
        int    gap;
        while (text_q.size() != 0) begin
            t = text_q.pop_front();
            send_req(t.b, t.first);
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = tx_calm ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin : rx_proc
        t_rx_pattern rx_mode;
        int          rx_left;
        int          rx_idx;
        int          hold_left;
        logic [7:0]  rx_mask;
        rx_mode = RX_STEADY;
        rx_left = 0;
        rx_idx = 0;
        hold_left = 0;
        rx_mask = 8'hff;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_result(o_out_byte, o_out_valid, o_status, o_last);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = 400;
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_pattern'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
                rx_mask = 8'($urandom_range(1, 255));
            end
            rx_left--;
            rx_idx = (rx_idx + 1) % 8;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STEADY: pop <= 1'b1;
                    RX_COIN: pop <= 1'($urandom_range(0, 1));
                    RX_MASK: pop <= rx_mask[rx_idx];
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : tx_proc
        int n_iter;
        int kinds;
        n_iter = 0;
        kinds = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Missing quote, a byte after the end, and a bare text end.
        add_text("a", 1'b1, 1'b1);
        add_text(8'hff, 1'b0, 1'b0);
        add_text(CH_NUL, 1'b1, 1'b1);
        // Body extremes, code point zero, the largest code point, a tab escape.
        add_text(CH_QUOTE, 1'b1, 1'b1);
        add_text(8'hff, 1'b0, 1'b1);
        add_text(CH_SPACE, 1'b0, 1'b1);
        add_unicode(16'h0000, 4);
        add_unicode(16'hffff, 4);
        add_text(CH_BSLASH, 1'b0, 1'b1);
        add_text(CH_T, 1'b0, 1'b1);
        add_text(CH_QUOTE, 1'b0, 1'b1);
        // Text end right after a backslash and inside the hex digits.
        add_text(CH_QUOTE, 1'b1, 1'b1);
        add_text(CH_BSLASH, 1'b0, 1'b1);
        add_text(CH_NUL, 1'b0, 1'b1);
        add_text(CH_QUOTE, 1'b1, 1'b1);
        add_unicode(16'h7000, 1);
        add_text(CH_NUL, 1'b0, 1'b1);
        // Control byte and an unterminated string.
        add_text(CH_QUOTE, 1'b1, 1'b1);
        add_text(8'h1f, 1'b0, 1'b1);
        add_text(CH_QUOTE, 1'b1, 1'b1);
        add_text(CH_NUL, 1'b0, 1'b1);
        send_all();
        drain();

        while (n_counted < ITEM_TARGET) begin
            n_iter++;
            tx_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                add_text(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            else
                add_string();
            send_all();
            if (n_iter == 8) begin
                tx_calm = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (n_iter % 30 == 0) drain();
        end
        drain();
        repeat (10) @(posedge i_clk);

        for (int s = 1; s < 7; s++)
            if (sb.status_hits[s] > 0) kinds++;
        $display("Fed %0d text bytes over %0d strings and checked %0d decoded results.",
                 sb.n_requests, sb.n_strings, sb.n_results);
        $display("Strings ended in %0d of the 6 ways: closing quote or an error kind.", kinds);
        if (sb.n_mismatch == 0 && sb.pending() == 0) begin
            $display("[json_string_unescape] OK");
        end else begin
            $display("Failures: %0d mismatches, %0d results never seen.",
                     sb.n_mismatch, sb.pending());
            $display("[json_string_unescape] ERROR");
        end
        $finish;
    end

endmodule

FILE: json_string_unescape.f
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_fifo.sv
src/jsu_back.sv
src/json_string_unescape.sv
src/jsu_checker.sv
tb/sv/tb_top.sv
